// File: design/egwm_pkg.sv
// Shared constants, snapshot type and modulo helper for the encoder gate window measure block.
package egwm_pkg;

    localparam int PULSES_PER_REV = 512;
    localparam int POS_W          = 10;
    localparam int OFF_W          = 9;
    localparam int START_W        = 9;
    localparam int WIDTH_W        = 10;

    localparam logic [POS_W-1:0] REV = POS_W'(PULSES_PER_REV);

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_FEW_EDGES = 1'b1;

    // Edge positions of one finished revolution, handed from the tracker to the arc stage.
    typedef struct packed {
        logic [POS_W-1:0] earlier;
        logic [POS_W-1:0] last;
        logic             few_edges;
    } egwm_snap_t;

    // Reduces a value below twice the revolution into the range of one revolution.
    function automatic logic [POS_W-1:0] mod_rev(input logic [POS_W:0] v);
        logic [POS_W:0] r;
        r = (v >= {1'b0, REV}) ? (v - {1'b0, REV}) : v;
        return r[POS_W-1:0];
    endfunction

endpackage

// File: design/egwm_tracker.sv
// Revolution tracker: counts pulses, records the last two gate edges and snapshots them at each index mark.
module egwm_tracker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               gate_level,
    input  logic               index_mark,
    output logic               snap_valid,
    input  logic               snap_stall,
    output egwm_pkg::egwm_snap_t snap
);
    import egwm_pkg::*;

    logic             running_reg, running_next;
    logic             prev_gate_reg, prev_gate_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] last_reg, last_next;
    logic [POS_W-1:0] earlier_reg, earlier_next;
    logic [1:0]       edges_reg, edges_next;
    logic             snap_valid_reg, snap_valid_next;
    egwm_snap_t       snap_reg, snap_next;

    logic accept;
    logic emit;
    logic [POS_W-1:0] pos_inc;

    // A finished revolution waits in the snapshot register until the arc stage takes it.
    assign in_stall = snap_valid_reg & snap_stall;
    assign accept   = in_valid & ~in_stall;
    assign emit     = accept & index_mark & running_reg;
    assign pos_inc  = (pos_reg < REV) ? (pos_reg + POS_W'(1)) : pos_reg;

    always_comb
    begin
        running_next   = running_reg;
        prev_gate_next = prev_gate_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        earlier_next   = earlier_reg;
        edges_next     = edges_reg;
        if (accept)
        begin
            if (index_mark)
            begin
                running_next   = 1'b1;
                prev_gate_next = 1'b0;
                pos_next       = '0;
                last_next      = '0;
                earlier_next   = '0;
                edges_next     = '0;
            end
            else if (running_reg)
            begin
                pos_next       = pos_inc;
                prev_gate_next = gate_level;
                if (gate_level != prev_gate_reg)
                begin
                    earlier_next = last_reg;
                    last_next    = pos_inc;
                    if (edges_reg < 2'd2)
                    begin
                        edges_next = edges_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        snap_next       = snap_reg;
        snap_valid_next = snap_valid_reg & snap_stall;
        if (emit)
        begin
            snap_next.earlier   = earlier_reg;
            snap_next.last      = last_reg;
            snap_next.few_edges = (edges_reg < 2'd2);
            snap_valid_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            prev_gate_reg  <= 1'b0;
            pos_reg        <= '0;
            last_reg       <= '0;
            earlier_reg    <= '0;
            edges_reg      <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            running_reg    <= running_next;
            prev_gate_reg  <= prev_gate_next;
            pos_reg        <= pos_next;
            last_reg       <= last_next;
            earlier_reg    <= earlier_next;
            edges_reg      <= edges_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

// File: design/egwm_arc.sv
// Arc stage: picks the shorter arc, applies the position offset and holds the result register.
module egwm_arc (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            snap_valid,
    output logic                            snap_stall,
    input  egwm_pkg::egwm_snap_t            snap,
    input  logic [egwm_pkg::OFF_W-1:0]      offset,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [egwm_pkg::START_W-1:0]    gate_start,
    output logic [egwm_pkg::START_W-1:0]    gate_end,
    output logic [egwm_pkg::WIDTH_W-1:0]    gate_width,
    output logic                            status
);
    import egwm_pkg::*;

    logic                 out_valid_reg, out_valid_next;
    logic [START_W-1:0]   start_reg, start_next;
    logic [START_W-1:0]   end_reg, end_next;
    logic [WIDTH_W-1:0]   width_reg, width_next;
    logic                 status_reg, status_next;

    logic                 take;
    logic [POS_W-1:0]     diff, other, arc_width;
    logic                 swap;
    logic [POS_W-1:0]     first_pos, second_pos;
    logic [POS_W-1:0]     off_mod;
    logic [POS_W-1:0]     first_adj, second_adj;

    assign snap_stall = out_valid_reg & out_stall;
    assign take       = snap_valid & ~snap_stall;

    always_comb
    begin
        diff      = snap.last - snap.earlier;
        other     = REV - diff;
        arc_width = (diff < other) ? diff : other;
        // When the arc through zero is the shorter one, it starts at the later edge.
        swap      = (diff > other);
        if (swap)
        begin
            first_pos  = mod_rev({1'b0, snap.last});
            second_pos = mod_rev({1'b0, snap.last} + {1'b0, arc_width});
        end
        else
        begin
            first_pos  = mod_rev({1'b0, snap.earlier});
            second_pos = mod_rev({1'b0, snap.last});
        end
        off_mod    = mod_rev({2'b00, offset});
        first_adj  = mod_rev({1'b0, first_pos} + {1'b0, REV} - {1'b0, off_mod});
        second_adj = mod_rev({1'b0, second_pos} + {1'b0, REV} - {1'b0, off_mod});
    end

    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        start_next     = start_reg;
        end_next       = end_reg;
        width_next     = width_reg;
        status_next    = status_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            if (snap.few_edges)
            begin
                start_next  = '0;
                end_next    = '0;
                width_next  = '0;
                status_next = STATUS_FEW_EDGES;
            end
            else
            begin
                start_next  = first_adj[START_W-1:0];
                end_next    = second_adj[START_W-1:0];
                width_next  = WIDTH_W'(arc_width);
                status_next = STATUS_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg  <= start_next;
        end_reg    <= end_next;
        width_reg  <= width_next;
        status_reg <= status_next;
    end

    assign out_valid  = out_valid_reg;
    assign gate_start = start_reg;
    assign gate_end   = end_reg;
    assign gate_width = width_reg;
    assign status     = status_reg;

endmodule

// File: design/encoder_gate_window_measure.sv
// Top level of the encoder gate window measure block.
// Each input transfer is one encoder pulse or an index mark, and one transfer is taken every clock
// cycle unless input stall is high. An index mark seen after the first one yields one result
// transfer describing the gate arc of the revolution just ended; the result passes through a
// snapshot register and then a result register. Input stall rises only when both of these
// hold an unread result and the output is stalled. The position offset register resets to 8 and
// should be written only while no result is pending.
module encoder_gate_window_measure (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            gate_level,
    input  logic                            index_mark,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [egwm_pkg::START_W-1:0]    gate_start,
    output logic [egwm_pkg::START_W-1:0]    gate_end,
    output logic [egwm_pkg::WIDTH_W-1:0]    gate_width,
    output logic                            status,
    input  logic                            cfg_write_en,
    input  logic [egwm_pkg::OFF_W-1:0]      cfg_write_data
);
    import egwm_pkg::*;

    logic [OFF_W-1:0] offset_reg;
    logic             snap_valid;
    logic             snap_stall;
    egwm_snap_t       snap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFF_W'(8);
        end
        else if (cfg_write_en)
        begin
            offset_reg <= cfg_write_data;
        end
    end

    egwm_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .gate_level (gate_level),
        .index_mark (index_mark),
        .snap_valid (snap_valid),
        .snap_stall (snap_stall),
        .snap       (snap)
    );

    egwm_arc u_arc (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_stall (snap_stall),
        .snap       (snap),
        .offset     (offset_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .gate_start (gate_start),
        .gate_end   (gate_end),
        .gate_width (gate_width),
        .status     (status)
    );

endmodule

// File: verif/egwm_arc_checker.sv
// Checker that predicts the gate arc of each revolution and compares it with the block's results.
module egwm_arc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            gate_level,
    input  logic                            index_mark,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [egwm_pkg::START_W-1:0]    gate_start,
    input  logic [egwm_pkg::START_W-1:0]    gate_end,
    input  logic [egwm_pkg::WIDTH_W-1:0]    gate_width,
    input  logic                            status,
    input  logic                            cfg_write_en,
    input  logic [egwm_pkg::OFF_W-1:0]      cfg_write_data,
    output int                              arcs_pending,
    output int                              mismatches
);
    import egwm_pkg::*;

    typedef struct packed {
        logic [START_W-1:0] arc_start;
        logic [START_W-1:0] arc_end;
        logic [WIDTH_W-1:0] arc_width;
        logic               few_edges;
    } arc_t;

    logic [OFF_W-1:0] offset_q;
    bit               running;
    bit               prev_level;
    int               pulse_pos;
    int               last_edge;
    int               earlier_edge;
    int               edge_count;
    arc_t             arc_q[$];

    function automatic arc_t measure_arc(input int first_pos, input int second_pos,
                                         input int edges, input int offset);
        arc_t a;
        int   span;
        int   rest;
        int   w;
        a = '0;
        if (edges < 2)
        begin
            a.few_edges = 1'b1;
            return a;
        end
        span = second_pos - first_pos;
        rest = PULSES_PER_REV - span;
        w = (span < rest) ? span : rest;
        // When the arc through zero is the shorter one, it starts at the later edge.
        if (span > rest)
        begin
            first_pos = second_pos;
            second_pos = (second_pos + w) % PULSES_PER_REV;
        end
        offset = offset % PULSES_PER_REV;
        a.arc_start = START_W'(((first_pos % PULSES_PER_REV) + PULSES_PER_REV - offset)
                               % PULSES_PER_REV);
        a.arc_end = START_W'(((second_pos % PULSES_PER_REV) + PULSES_PER_REV - offset)
                             % PULSES_PER_REV);
        a.arc_width = WIDTH_W'(w);
        return a;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        arc_t exp_arc;
        if (!rst_n)
        begin
            offset_q = OFF_W'(8);
            running = 1'b0;
            prev_level = 1'b0;
            pulse_pos = 0;
            last_edge = 0;
            earlier_edge = 0;
            edge_count = 0;
            arc_q.delete();
            arcs_pending = 0;
            mismatches = 0;
        end
        else
        begin
            if (cfg_write_en)
                offset_q = cfg_write_data;

            if (out_valid && !out_stall)
            begin
                if (arc_q.size() == 0)
                    report_mismatch("result transfer with no arc expected");
                else
                begin
                    exp_arc = arc_q.pop_front();
                    if (gate_start !== exp_arc.arc_start)
                        report_mismatch($sformatf("gate_start %0d, expected %0d",
                                                  gate_start, exp_arc.arc_start));
                    if (gate_end !== exp_arc.arc_end)
                        report_mismatch($sformatf("gate_end %0d, expected %0d",
                                                  gate_end, exp_arc.arc_end));
                    if (gate_width !== exp_arc.arc_width)
                        report_mismatch($sformatf("gate_width %0d, expected %0d",
                                                  gate_width, exp_arc.arc_width));
                    if (status !== exp_arc.few_edges)
                        report_mismatch($sformatf("status %0b, expected %0b",
                                                  status, exp_arc.few_edges));
                end
            end

            if (in_valid && !in_stall)
            begin
                if (index_mark)
                begin
                    if (running)
                        arc_q.push_back(measure_arc(earlier_edge, last_edge, edge_count,
                                                    int'(offset_q)));
                    running = 1'b1;
                    prev_level = 1'b0;
                    pulse_pos = 0;
                    last_edge = 0;
                    earlier_edge = 0;
                    edge_count = 0;
                end
                else if (running)
                begin
                    if (pulse_pos < PULSES_PER_REV)
                        pulse_pos++;
                    if (gate_level != prev_level)
                    begin
                        earlier_edge = last_edge;
                        last_edge = pulse_pos;
                        if (edge_count < 2)
                            edge_count++;
                    end
                    prev_level = gate_level;
                end
            end
            arcs_pending = arc_q.size();
        end
    end

endmodule

// File: verif/encoder_gate_window_measure_tb.sv
// Testbench top: drives encoder pulses, index marks and offset writes, and gives the verdict.
module encoder_gate_window_measure_tb;
    import egwm_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               gate_level;
    logic               index_mark;
    logic               out_valid;
    logic               out_stall;
    logic [START_W-1:0] gate_start;
    logic [START_W-1:0] gate_end;
    logic [WIDTH_W-1:0] gate_width;
    logic               status;
    logic               cfg_write_en;
    logic [OFF_W-1:0]   cfg_write_data;
    int                 arcs_pending;
    int                 mismatches;

    // While steady is set neither side inserts gaps.
    bit                 steady;
    bit                 hold_request;
    bit                 holding;

    always #2 clk = ~clk;

    encoder_gate_window_measure dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .gate_level     (gate_level),
        .index_mark     (index_mark),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .gate_start     (gate_start),
        .gate_end       (gate_end),
        .gate_width     (gate_width),
        .status         (status),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    egwm_arc_checker arc_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .gate_level     (gate_level),
        .index_mark     (index_mark),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .gate_start     (gate_start),
        .gate_end       (gate_end),
        .gate_width     (gate_width),
        .status         (status),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .arcs_pending   (arcs_pending),
        .mismatches     (mismatches)
    );

    function automatic int unsigned idle_len();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_pulse(input logic level, input logic mark);
        int unsigned gap;
        in_valid <= 1'b1;
        gate_level <= level;
        index_mark <= mark;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        gap = idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            gate_level <= 1'($urandom_range(0, 1));
            index_mark <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
        end
    endtask

    // Gate is high on pulses rise_at up to fall_at - 1; the revolution closes with a mark.
    task automatic send_revolution(input int unsigned len, input int unsigned rise_at,
                                   input int unsigned fall_at);
        for (int unsigned k = 1; k <= len; k++)
            send_pulse(k >= rise_at && k < fall_at, 1'b0);
        send_pulse(1'($urandom_range(0, 1)), 1'b1);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (arcs_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_offset(input logic [OFF_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: random stalls, plus one long hold-off when requested.
    initial
    begin
        out_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                holding = 1'b1;
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_request = 1'b0;
                holding = 1'b0;
            end
            else if (!steady && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat (idle_len() + 1) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int unsigned      phase_pulses;
        int unsigned      len;
        int unsigned      rise_at;
        int unsigned      fall_at;
        logic [OFF_W-1:0] phase_offset[4];

        rst_n = 1'b0;
        in_valid = 1'b0;
        gate_level = 1'b0;
        index_mark = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        steady = 1'b0;
        hold_request = 1'b0;
        holding = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pulses before the first mark are ignored.
        send_pulse(1'b1, 1'b0);
        send_pulse(1'b0, 1'b0);
        send_pulse(1'b1, 1'b0);
        send_pulse(1'b1, 1'b1);
        // An empty revolution and one with a single edge both report too few edges.
        send_pulse(1'b0, 1'b1);
        send_pulse(1'b1, 1'b0);
        send_pulse(1'b1, 1'b0);
        send_pulse(1'b0, 1'b1);
        // Short arc near zero, so the default offset wraps the start below zero.
        send_revolution(4, 2, 4);
        // More than two edges: only the last two count.
        send_pulse(1'b1, 1'b0);
        send_pulse(1'b0, 1'b0);
        send_pulse(1'b1, 1'b0);
        send_pulse(1'b0, 1'b0);
        send_pulse(1'b1, 1'b1);
        settle();

        // Long revolutions: wrapped arc, saturated position, equal arcs.
        write_offset('0);
        send_revolution(530, 1, 513);
        send_revolution(260, 2, 258);
        settle();

        phase_offset[0] = '1;
        phase_offset[1] = OFF_W'($urandom_range(0, 511));
        phase_offset[2] = OFF_W'(256);
        phase_offset[3] = OFF_W'($urandom_range(0, 511));
        for (int ph = 0; ph < 4; ph++)
        begin
            write_offset(phase_offset[ph]);
            if (ph == 1)
            begin
                // Keep offering marks while the receiver holds off so the block backs up.
                hold_request = 1'b1;
                while (!holding)
                    @(posedge clk);
                steady = 1'b1;
                for (int r = 0; r < 20; r++)
                begin
                    rise_at = $urandom_range(1, 3);
                    send_revolution($urandom_range(0, 3), rise_at, $urandom_range(rise_at, 4));
                end
                steady = 1'b0;
            end
            phase_pulses = 0;
            while (phase_pulses < 75)
            begin
                steady = ($urandom_range(0, 7) == 0);
                len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 40)
                                                   : $urandom_range(41, 200);
                if ($urandom_range(0, 9) < 7)
                begin
                    rise_at = $urandom_range(1, len + 1);
                    fall_at = $urandom_range(rise_at, len + 1);
                    send_revolution(len, rise_at, fall_at);
                end
                else
                begin
                    for (int unsigned k = 0; k < len; k++)
                        send_pulse(1'($urandom_range(0, 1)), 1'b0);
                    send_pulse(1'($urandom_range(0, 1)), 1'b1);
                end
                phase_pulses += len + 1;
            end
            steady = 1'b0;
            settle();
        end

        if (mismatches == 0 && arcs_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
design/egwm_pkg.sv
design/egwm_tracker.sv
design/egwm_arc.sv
design/encoder_gate_window_measure.sv
verif/egwm_arc_checker.sv
verif/encoder_gate_window_measure_tb.sv
